// File: design/bpsp_pkg.sv
// Package: shared constants, types and exponent tables of the softmax perceptron.
package bpsp_pkg;
	localparam int CLASSES_DEF = 13;
	localparam int PIXELS_DEF = 936;
	localparam int WEIGHT_BITS_DEF = 24;
	localparam int BIAS_GAIN_DEF = 100;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_CLASSIFY = 2'd2;
	localparam logic [1:0] CMD_TRAIN = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDWAIT, ST_PIX, ST_BIAS, ST_MAX, ST_EXP, ST_EXP2,
		ST_DIV, ST_OUT, ST_TRAIN, ST_DONE
	} state_t;

	function automatic logic [16:0] exp_int(input logic [3:0] n);
		case (n)
			4'd0: exp_int = 17'd65536;
			4'd1: exp_int = 17'd24109;
			4'd2: exp_int = 17'd8869;
			4'd3: exp_int = 17'd3263;
			4'd4: exp_int = 17'd1200;
			4'd5: exp_int = 17'd442;
			4'd6: exp_int = 17'd162;
			4'd7: exp_int = 17'd60;
			4'd8: exp_int = 17'd22;
			4'd9: exp_int = 17'd8;
			4'd10: exp_int = 17'd3;
			4'd11: exp_int = 17'd1;
			default: exp_int = 17'd0;
		endcase
	endfunction

	function automatic logic [16:0] exp_hi(input logic [3:0] h);
		case (h)
			4'd0: exp_hi = 17'd65536;
			4'd1: exp_hi = 17'd61565;
			4'd2: exp_hi = 17'd57835;
			4'd3: exp_hi = 17'd54331;
			4'd4: exp_hi = 17'd51039;
			4'd5: exp_hi = 17'd47947;
			4'd6: exp_hi = 17'd45042;
			4'd7: exp_hi = 17'd42314;
			4'd8: exp_hi = 17'd39750;
			4'd9: exp_hi = 17'd37341;
			4'd10: exp_hi = 17'd35079;
			4'd11: exp_hi = 17'd32954;
			4'd12: exp_hi = 17'd30957;
			4'd13: exp_hi = 17'd29081;
			4'd14: exp_hi = 17'd27319;
			default: exp_hi = 17'd25664;
		endcase
	endfunction

	function automatic logic [16:0] exp_lo(input logic [3:0] l);
		case (l)
			4'd0: exp_lo = 17'd65536;
			4'd1: exp_lo = 17'd65280;
			4'd2: exp_lo = 17'd65026;
			4'd3: exp_lo = 17'd64772;
			4'd4: exp_lo = 17'd64520;
			4'd5: exp_lo = 17'd64268;
			4'd6: exp_lo = 17'd64018;
			4'd7: exp_lo = 17'd63768;
			4'd8: exp_lo = 17'd63520;
			4'd9: exp_lo = 17'd63272;
			4'd10: exp_lo = 17'd63025;
			4'd11: exp_lo = 17'd62780;
			4'd12: exp_lo = 17'd62535;
			4'd13: exp_lo = 17'd62291;
			4'd14: exp_lo = 17'd62048;
			default: exp_lo = 17'd61806;
		endcase
	endfunction
endpackage

// File: design/bpsp_ram.sv
// Generic single-port RAM with registered read.
module bpsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: design/bpsp_div.sv
// Restoring divider: quotient of a 33-bit numerator by a divisor, one bit a cycle.
module bpsp_div #(
	parameter int NB = 33,
	parameter int DB = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NB-1:0] num,
	input  logic [DB-1:0] den,
	output logic          done,
	output logic [NB-1:0] quot
);
	logic [NB-1:0] quot_q;
	logic [DB:0] rem_q;
	logic [DB-1:0] den_q;
	logic [$clog2(NB+1)-1:0] cnt_q;
	logic [DB:0] trial;

	assign trial = {rem_q[DB-1:0], quot_q[NB-1]};
	assign quot = quot_q;
	assign done = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= ($clog2(NB+1))'(NB);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quot_q <= {quot_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[NB-2:0], 1'b0};
			end
		end
	end
endmodule

// File: design/binary_pixel_softmax_perceptron.sv
// Top level: single-layer binary-image perceptron with softmax and training.
// Weights live in one RAM of CLASSES*(PIXELS+1) words; each class row holds
// PIXELS weights and then the bias. A weight write is done as it is accepted;
// a read's data passes the RAM output register and RDWAIT, then is offered.
// A pixel transaction reads the CLASSES weights of its column one per cycle
// from the single RAM port. The last pixel then runs the softmax: bias reads,
// max, exponent, one divide per class, and in train mode a read-modify-write
// sweep of the whole RAM. No clearing pass: unwritten weights are
// undefined. tdata in: class_index, weight_index, weight_value, pixel,
// target_class; tlast in: last_pixel; tuser in: cmd. tdata out: weight_data,
// best_class, best_prob, image_error; tuser out: result_kind.
module binary_pixel_softmax_perceptron #(
	parameter int CLASSES = bpsp_pkg::CLASSES_DEF,
	parameter int PIXELS = bpsp_pkg::PIXELS_DEF,
	parameter int WEIGHT_BITS = bpsp_pkg::WEIGHT_BITS_DEF,
	parameter int BIAS_GAIN = bpsp_pkg::BIAS_GAIN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// class_index[3:0], weight_index[13:4], weight_value[37:14], pixel[38],
	// target_class[42:39]
	input  logic [47:0] s_tdata,
	// last_pixel
	input  logic        s_tlast,
	// cmd[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// weight_data[23:0], best_class[27:24], best_prob[43:28], image_error[44]
	output logic [47:0] m_tdata,
	// result_kind[0]
	output logic        m_tuser
);
	localparam int ROW = PIXELS + 1;
	localparam int DEPTH = CLASSES * ROW;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(CLASSES);
	localparam int PW = $clog2(PIXELS + 2);
	localparam int IW = $clog2(PIXELS + 1);
	localparam int XW = $clog2(PIXELS);
	localparam int SW = WEIGHT_BITS + $clog2(PIXELS + 2) + 1;
	localparam int EW = 17 + $clog2(CLASSES + 1);
	localparam logic signed [WEIGHT_BITS:0] WMAX = (WEIGHT_BITS+1)'((1 << (WEIGHT_BITS-1)) - 1);
	localparam logic signed [WEIGHT_BITS:0] WMIN = -WMAX - 1;

	logic [1:0] cmd;
	logic [3:0] in_cls, tgt;
	logic [9:0] in_idx;
	logic [23:0] in_val;
	logic in_pix, in_last;
	assign cmd = s_tuser;
	assign in_cls = s_tdata[3:0];
	assign in_idx = s_tdata[13:4];
	assign in_val = s_tdata[37:14];
	assign in_pix = s_tdata[38];
	assign tgt = s_tdata[42:39];
	assign in_last = s_tlast;

	bpsp_pkg::state_t st_q, st_d;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [WEIGHT_BITS-1:0] ram_wdata, ram_rdata;
	bpsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_wram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	logic pix_we, pix_rdata;
	logic [XW-1:0] pix_addr;
	logic pix_wd;
	bpsp_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_pram (
		.clk(clk), .we(pix_we), .addr(pix_addr), .wdata(pix_wd), .rdata(pix_rdata)
	);

	logic signed [SW-1:0] score_q [CLASSES];
	logic [16:0] e_q [CLASSES];
	logic [15:0] prob_q [CLASSES];
	logic [PW-1:0] cnt_q;
	logic train_q, last_q, white_q, rdrange_q;
	logic [3:0] tgt_q;
	logic [CW:0] ci_q;
	logic [AW-1:0] addr_q;
	logic [IW-1:0] col_q;
	logic signed [SW-1:0] mx_q;
	logic [EW-1:0] sum_q;
	logic [16:0] e1_q;
	logic signed [9:0] q_q;
	logic rv_q;
	logic [CW-1:0] best_q;
	logic err_q;

	logic div_start, div_done;
	logic [32:0] div_quot;
	logic [32:0] div_num;
	// e * 2^16 + sum/2, rounded quotient
	assign div_num = ({16'd0, e_q[ci_q[CW-1:0]]} << 16) + 33'(sum_q >> 1);
	bpsp_div #(.NB(33), .DB(EW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(sum_q),
		.done(div_done), .quot(div_quot)
	);

	function automatic logic [33:0] exp_calc1(input logic [3:0] n, input logic [3:0] h);
		exp_calc1 = bpsp_pkg::exp_int(n) * bpsp_pkg::exp_hi(h);
	endfunction

	logic signed [WEIGHT_BITS-1:0] rw;
	assign rw = ram_rdata;
	logic signed [SW-1:0] dsc;
	logic [SW-1:0] dd;
	logic [33:0] m1, m2;
	logic signed [17:0] delta;
	logic [16:0] mag;
	logic signed [9:0] qn;
	logic signed [WEIGHT_BITS+8:0] upd;
	logic signed [20:0] bq;
	logic ok_range;
	logic out_free;

	assign out_free = !m_tvalid || m_tready;
	assign ok_range = ({28'd0, in_cls} < CLASSES) && (in_idx <= 10'(PIXELS));
	assign dsc = mx_q - score_q[ci_q[CW-1:0]];
	assign dd = dsc;
	assign m1 = (dd >= SW'(12*256)) ? 34'd0 :
		exp_calc1(dd[11:8], dd[7:4]);
	assign m2 = e1_q * bpsp_pkg::exp_lo(dd[3:0]);
	assign delta = (18'(tgt_q) == 18'(ci_q) ? 18'sd65536 : 18'sd0)
		- $signed({2'b0, prob_q[ci_q[CW-1:0]]});
	assign mag = delta < 0 ? 17'(-delta) : 17'(delta);
	assign qn = delta < 0 ? -$signed(10'((mag + 17'd128) >> 8))
		: $signed(10'((mag + 17'd128) >> 8));
	assign bq = 21'(q_q) * 21'(BIAS_GAIN);
	assign upd = (col_q == IW'(PIXELS)) ? (WEIGHT_BITS+9)'(rw) + (WEIGHT_BITS+9)'(bq)
		: (pix_rdata ? (WEIGHT_BITS+9)'(rw) - (WEIGHT_BITS+9)'(q_q)
		: (WEIGHT_BITS+9)'(rw) + (WEIGHT_BITS+9)'(q_q));

	assign s_tready = (st_q == bpsp_pkg::ST_IDLE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bpsp_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		ram_we = 1'b0;
		ram_addr = addr_q;
		ram_wdata = WEIGHT_BITS'(in_val);
		pix_we = 1'b0;
		pix_addr = cnt_q[XW-1:0];
		pix_wd = in_pix;
		div_start = 1'b0;
		case (st_q)
			bpsp_pkg::ST_IDLE: begin
				ram_addr = AW'(in_cls * ROW + in_idx);
				if (s_tvalid && s_tready) begin
					case (cmd)
						bpsp_pkg::CMD_WRITE: ram_we = ok_range;
						bpsp_pkg::CMD_READ: st_d = bpsp_pkg::ST_RDWAIT;
						default: begin
							ram_addr = AW'(cnt_q);
							pix_we = cnt_q < PW'(PIXELS);
							st_d = bpsp_pkg::ST_PIX;
						end
					endcase
				end
			end
			bpsp_pkg::ST_RDWAIT: st_d = bpsp_pkg::ST_IDLE;
			bpsp_pkg::ST_PIX: begin
				if (ci_q == (CW+1)'(CLASSES - 1)) begin
					st_d = last_q ? bpsp_pkg::ST_BIAS : bpsp_pkg::ST_IDLE;
				end
			end
			bpsp_pkg::ST_BIAS: if (ci_q == (CW+1)'(CLASSES - 1)) st_d = bpsp_pkg::ST_MAX;
			bpsp_pkg::ST_MAX: if (ci_q == (CW+1)'(CLASSES - 1)) st_d = bpsp_pkg::ST_EXP;
			bpsp_pkg::ST_EXP: st_d = bpsp_pkg::ST_EXP2;
			bpsp_pkg::ST_EXP2: begin
				if (ci_q == (CW+1)'(CLASSES - 1)) begin
					st_d = bpsp_pkg::ST_DIV;
				end else begin
					st_d = bpsp_pkg::ST_EXP;
				end
			end
			bpsp_pkg::ST_DIV: begin
				div_start = !rv_q;
				if (rv_q && div_done && ci_q == (CW+1)'(CLASSES - 1)) st_d = bpsp_pkg::ST_OUT;
			end
			bpsp_pkg::ST_OUT: begin
				if (train_q && !err_q && ({28'd0, tgt_q} < CLASSES)) begin
					st_d = bpsp_pkg::ST_TRAIN;
				end else begin
					st_d = bpsp_pkg::ST_DONE;
				end
			end
			bpsp_pkg::ST_TRAIN: begin
				pix_addr = col_q[XW-1:0];
				ram_wdata = upd > (WEIGHT_BITS+9)'(WMAX) ? WMAX[WEIGHT_BITS-1:0] :
					upd < (WEIGHT_BITS+9)'(WMIN) ? WMIN[WEIGHT_BITS-1:0] :
					upd[WEIGHT_BITS-1:0];
				ram_we = rv_q;
				if (rv_q && ci_q == (CW+1)'(CLASSES - 1) && col_q == IW'(PIXELS))
					st_d = bpsp_pkg::ST_DONE;
			end
			bpsp_pkg::ST_DONE: if (out_free) st_d = bpsp_pkg::ST_IDLE;
			default: st_d = bpsp_pkg::ST_IDLE;
		endcase
	end

	// Sequencing registers and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			train_q <= 1'b0;
			ci_q <= '0;
			rv_q <= 1'b0;
			m_tvalid <= 1'b0;
			for (int c = 0; c < CLASSES; c++) score_q[c] <= '0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (st_q)
				bpsp_pkg::ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						addr_q <= AW'(ROW) + AW'(cnt_q);
						ci_q <= '0;
						rdrange_q <= ok_range;
						if (cmd == bpsp_pkg::CMD_CLASSIFY || cmd == bpsp_pkg::CMD_TRAIN) begin
							if (cnt_q == '0) train_q <= (cmd == bpsp_pkg::CMD_TRAIN);
							if (cnt_q <= PW'(PIXELS)) cnt_q <= cnt_q + 1'b1;
							rv_q <= cnt_q < PW'(PIXELS);
							white_q <= in_pix;
							last_q <= in_last;
							tgt_q <= tgt;
						end
					end
				end
				bpsp_pkg::ST_RDWAIT: begin
					m_tvalid <= 1'b1;
					m_tuser <= 1'b0;
					m_tdata <= {24'd0, rdrange_q ? 24'(rw) : 24'd0};
				end
				bpsp_pkg::ST_PIX: begin
					addr_q <= addr_q + AW'(ROW);
					ci_q <= ci_q + 1'b1;
					if (rv_q) begin
						score_q[ci_q[CW-1:0]] <= white_q ? score_q[ci_q[CW-1:0]] - SW'(rw)
							: score_q[ci_q[CW-1:0]] + SW'(rw);
					end
					if (ci_q == (CW+1)'(CLASSES - 1)) begin
						ci_q <= '0;
						rv_q <= 1'b0;
						addr_q <= AW'(PIXELS);
						err_q <= cnt_q != PW'(PIXELS);
					end
				end
				bpsp_pkg::ST_BIAS: begin
					// First cycle only issues; results arrive one behind.
					addr_q <= addr_q + AW'(ROW);
					if (!rv_q) begin
						rv_q <= 1'b1;
					end else begin
						score_q[ci_q[CW-1:0]] <= score_q[ci_q[CW-1:0]] + SW'(rw);
						ci_q <= ci_q + 1'b1;
						if (ci_q == (CW+1)'(CLASSES - 1)) begin
							ci_q <= '0;
							mx_q <= score_q[0];
						end
					end
				end
				bpsp_pkg::ST_MAX: begin
					if (score_q[ci_q[CW-1:0]] > mx_q) mx_q <= score_q[ci_q[CW-1:0]];
					ci_q <= ci_q + 1'b1;
					if (ci_q == (CW+1)'(CLASSES - 1)) begin
						ci_q <= '0;
						sum_q <= '0;
					end
				end
				bpsp_pkg::ST_EXP: e1_q <= 17'((m1 + 34'd32768) >> 16);
				bpsp_pkg::ST_EXP2: begin
					e_q[ci_q[CW-1:0]] <= 17'((m2 + 34'd32768) >> 16);
					sum_q <= sum_q + EW'((m2 + 34'd32768) >> 16);
					ci_q <= ci_q + 1'b1;
					if (ci_q == (CW+1)'(CLASSES - 1)) begin
						ci_q <= '0;
						rv_q <= 1'b0;
						best_q <= '0;
					end
				end
				bpsp_pkg::ST_DIV: begin
					if (!rv_q) begin
						rv_q <= 1'b1;
					end else if (div_done) begin
						rv_q <= 1'b0;
						prob_q[ci_q[CW-1:0]] <= div_quot > 33'd65535 ? 16'hFFFF : div_quot[15:0];
						if ((div_quot > 33'd65535 ? 16'hFFFF : div_quot[15:0]) > prob_q[best_q]
							&& ci_q != '0) best_q <= ci_q[CW-1:0];
						ci_q <= ci_q + 1'b1;
						if (ci_q == (CW+1)'(CLASSES - 1)) ci_q <= '0;
					end
				end
				bpsp_pkg::ST_OUT: begin
					m_tvalid <= 1'b1;
					m_tuser <= 1'b1;
					m_tdata <= {3'd0, err_q, prob_q[best_q], 4'(best_q), 24'd0};
					addr_q <= '0;
					col_q <= '0;
					rv_q <= 1'b0;
					ci_q <= '0;
				end
				bpsp_pkg::ST_TRAIN: begin
					// Each weight is read, then written back.
					if (!rv_q) begin
						rv_q <= 1'b1;
						q_q <= qn;
					end else begin
						rv_q <= 1'b0;
						addr_q <= addr_q + 1'b1;
						col_q <= col_q + 1'b1;
						if (col_q == IW'(PIXELS)) begin
							col_q <= '0;
							ci_q <= ci_q + 1'b1;
						end
					end
				end
				bpsp_pkg::ST_DONE: begin
					if (out_free) begin
						cnt_q <= '0;
						train_q <= 1'b0;
						for (int c = 0; c < CLASSES; c++) score_q[c] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// A new item is never taken while the sequencer is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> st_q == bpsp_pkg::ST_IDLE) else $error("ready while busy");
	// A weight write never happens during a pixel or softmax phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (st_q == bpsp_pkg::ST_IDLE || st_q == bpsp_pkg::ST_TRAIN))
		else $error("stray weight write");
	// Pixel count never passes its saturation point.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= PW'(PIXELS + 1)) else $error("pixel count overflow");
endmodule

// File: test/testbench.sv
// Testbench for the softmax perceptron: streamed stimulus checked against a built-in predictor.
`timescale 1ns / 1ps

module testbench;
	localparam int NCLS = bpsp_pkg::CLASSES_DEF;
	localparam int NPIX = bpsp_pkg::PIXELS_DEF;
	localparam int ROWLEN = NPIX + 1;
	localparam int WBITS = bpsp_pkg::WEIGHT_BITS_DEF;
	localparam int GAIN = bpsp_pkg::BIAS_GAIN_DEF;
	localparam int USED_COLS = 8;  // leading columns that short images touch
	localparam longint unsigned ONE_Q16 = 65536;

	// one input transaction, fields as the block sees them
	typedef struct {
		logic [1:0]  cmd;
		logic [3:0]  cls;
		logic [9:0]  widx;
		logic [23:0] wval;
		logic        px;
		logic        last;
		logic [3:0]  target;
		bit          drain;  // hold off until every pending result is back
	} request_t;

	// one output transaction
	typedef struct {
		logic        kind;
		logic [23:0] wdata;
		logic [3:0]  best;
		logic [15:0] prob;
		logic        err;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // class_index, weight_index, weight_value, pixel, target_class
	logic        s_tlast;  // last_pixel
	logic [1:0]  s_tuser;  // cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;  // weight_data, best_class, best_prob, image_error
	logic        m_tuser;  // result_kind

	binary_pixel_softmax_perceptron u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	request_t pending_items[$];
	outcome_t expected_results[$];
	request_t on_bus;
	int errors = 0;
	bit took = 0;
	int send_gap = 0;
	int recv_gap = 0;

	// shadow of the block's state
	int weights[NCLS][ROWLEN];
	longint class_sums[NCLS];
	bit pixel_bits[NPIX];
	int unsigned pixel_count = 0;
	bit training = 0;

	// exp(-x) pieces in Q16: whole units, sixteenths, 1/256ths
	longint unsigned exp_whole[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
	longint unsigned exp_coarse[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42314,
		39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
	longint unsigned exp_fine[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
		63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int clamp_weight(longint v);
		longint hi;
		hi = (longint'(1) <<< (WBITS - 1)) - 1;
		if (v > hi) return int'(hi);
		if (v < -hi - 1) return int'(-hi - 1);
		return int'(v);
	endfunction

	function automatic longint unsigned softmax_term(longint unsigned d);
		longint unsigned n;
		longint unsigned e;
		n = d >> 8;
		if (n >= 12) return 0;
		e = (exp_whole[n] * exp_coarse[d[7:4]] + 32768) >> 16;
		e = (e * exp_fine[d[3:0]] + 32768) >> 16;
		return e;
	endfunction

	// end of image: bias, softmax, argmax, then the training sweep
	function automatic outcome_t close_image(logic [3:0] target);
		longint unsigned e[NCLS];
		longint unsigned prob[NCLS];
		longint unsigned sum;
		longint unsigned p;
		longint top;
		longint delta;
		longint q;
		int best;
		bit bad;
		outcome_t r;
		sum = 0;
		best = 0;
		bad = (pixel_count != NPIX);
		for (int c = 0; c < NCLS; c++) class_sums[c] += weights[c][NPIX];
		top = class_sums[0];
		for (int c = 1; c < NCLS; c++) if (class_sums[c] > top) top = class_sums[c];
		for (int c = 0; c < NCLS; c++) begin
			e[c] = softmax_term(longint'(top - class_sums[c]));
			sum += e[c];
		end
		for (int c = 0; c < NCLS; c++) begin
			p = (sum == 0) ? 0 : (e[c] * ONE_Q16 + sum / 2) / sum;
			prob[c] = (p > 65535) ? 65535 : p;
			if (prob[c] > prob[best]) best = c;
		end
		if (training && !bad && target < NCLS) begin
			for (int c = 0; c < NCLS; c++) begin
				delta = ((c == target) ? longint'(ONE_Q16) : 0) - longint'(prob[c]);
				q = ((delta < 0 ? -delta : delta) + 128) >>> 8;
				if (delta < 0) q = -q;
				for (int i = 0; i < NPIX; i++)
					weights[c][i] = clamp_weight(longint'(weights[c][i]) + (pixel_bits[i] ? -q : q));
				weights[c][NPIX] = clamp_weight(longint'(weights[c][NPIX]) + GAIN * q);
			end
		end
		r.kind = 1'b1;
		r.wdata = '0;
		r.best = best[3:0];
		r.prob = prob[best][15:0];
		r.err = bad;
		for (int c = 0; c < NCLS; c++) class_sums[c] = 0;
		pixel_count = 0;
		training = 0;
		return r;
	endfunction

	// advance the shadow state by one accepted transaction
	task automatic predict_item(request_t it);
		bit in_range;
		int w;
		outcome_t r;
		in_range = (it.cls < NCLS) && (it.widx <= NPIX);
		case (it.cmd)
			bpsp_pkg::CMD_WRITE: begin
				if (in_range) weights[it.cls][it.widx] = int'($signed(it.wval));
			end
			bpsp_pkg::CMD_READ: begin
				w = in_range ? weights[it.cls][it.widx] : 0;
				r.kind = 1'b0;
				r.wdata = w[23:0];
				r.best = '0;
				r.prob = '0;
				r.err = 1'b0;
				expected_results.insert(expected_results.size(), r);
			end
			default: begin
				if (pixel_count == 0) training = (it.cmd == bpsp_pkg::CMD_TRAIN);
				if (pixel_count < NPIX) begin
					pixel_bits[pixel_count] = it.px;
					for (int c = 0; c < NCLS; c++)
						class_sums[c] += it.px ? -longint'(weights[c][pixel_count])
							: longint'(weights[c][pixel_count]);
				end
				if (pixel_count <= NPIX) pixel_count++;
				if (it.last)
					expected_results.insert(expected_results.size(), close_image(it.target));
			end
		endcase
	endtask

	task automatic note_mismatch(string field, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// ---- stimulus builders ----
	function automatic logic [23:0] small_weight();
		int v;
		v = int'($urandom_range(0, 64)) - 32;
		return v[23:0];
	endfunction

	// a column that was written up front: one of the leading ones or the bias
	function automatic logic [9:0] written_col();
		int i;
		i = int'($urandom_range(0, USED_COLS));
		return (i == USED_COLS) ? 10'(NPIX) : 10'(i);
	endfunction

	function automatic void push_access(logic [1:0] cmd, logic [3:0] cls, logic [9:0] idx,
		logic [23:0] val);
		request_t it;
		it.cmd = cmd;
		it.cls = cls;
		it.widx = idx;
		it.wval = val;
		it.px = 1'($urandom_range(0, 1));
		it.last = 1'($urandom_range(0, 1));
		it.target = 4'($urandom_range(0, 15));
		it.drain = 0;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// an access whose class or column lies outside the array
	function automatic void push_outside(logic [1:0] cmd);
		if ($urandom_range(0, 1))
			push_access(cmd, 4'($urandom_range(NCLS, 15)), 10'($urandom_range(0, 1023)),
				24'($urandom));
		else
			push_access(cmd, 4'($urandom_range(0, 15)), 10'($urandom_range(ROWLEN, 1023)),
				24'($urandom));
	endfunction

	function automatic void push_pixel(logic [1:0] cmd, bit last, logic [3:0] target, bit drain);
		request_t it;
		it.cmd = cmd;
		it.cls = 4'($urandom_range(0, 15));
		it.widx = 10'($urandom_range(0, 1023));
		it.wval = 24'($urandom);
		it.px = 1'($urandom_range(0, 1));
		it.last = last;
		it.target = target;
		it.drain = drain;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// an image of n pixels; mixed varies the command after the first pixel
	function automatic void push_image(logic [1:0] cmd, int n, logic [3:0] target, bit mixed,
		bit drain);
		logic [1:0] c;
		for (int k = 0; k < n; k++) begin
			c = (mixed && k > 0) ? ($urandom_range(0, 1) ? bpsp_pkg::CMD_TRAIN
				: bpsp_pkg::CMD_CLASSIFY) : cmd;
			push_pixel(c, k == n - 1, target, drain && k == 0);
		end
	endfunction

	initial begin
		int pick;
		// every weight a short image or an access can touch is written first
		for (int c = 0; c < NCLS; c++) begin
			for (int i = 0; i < USED_COLS; i++)
				push_access(bpsp_pkg::CMD_WRITE, 4'(c), 10'(i), small_weight());
			push_access(bpsp_pkg::CMD_WRITE, 4'(c), 10'(NPIX), small_weight());
		end

		// extremes, and addresses outside the array
		push_access(bpsp_pkg::CMD_WRITE, 4'd0, 10'd0, 24'h7FFFFF);
		push_access(bpsp_pkg::CMD_WRITE, 4'd12, 10'd936, 24'h800000);
		push_access(bpsp_pkg::CMD_READ, 4'd0, 10'd0, 24'($urandom));
		push_access(bpsp_pkg::CMD_READ, 4'd12, 10'd936, 24'($urandom));
		push_access(bpsp_pkg::CMD_WRITE, 4'd13, 10'd5, 24'h123456);
		push_access(bpsp_pkg::CMD_WRITE, 4'd0, 10'd937, 24'h654321);
		push_access(bpsp_pkg::CMD_WRITE, 4'd15, 10'd1023, 24'hFFFFFF);
		push_access(bpsp_pkg::CMD_READ, 4'd13, 10'd5, 24'($urandom));
		push_access(bpsp_pkg::CMD_READ, 4'd0, 10'd937, 24'($urandom));
		push_access(bpsp_pkg::CMD_READ, 4'd15, 10'd1023, 24'($urandom));
		push_access(bpsp_pkg::CMD_READ, 4'd3, 10'd5, 24'($urandom));

		// short images: no training, error flagged; the second waits for all results
		push_image(bpsp_pkg::CMD_CLASSIFY, 1, 4'd0, 0, 0);
		push_image(bpsp_pkg::CMD_TRAIN, 3, 4'd2, 0, 1);
		push_image(bpsp_pkg::CMD_CLASSIFY, 4, 4'd5, 1, 0);
		// weight access in the middle of an image
		push_pixel(bpsp_pkg::CMD_TRAIN, 0, 4'd0, 0);
		push_access(bpsp_pkg::CMD_WRITE, 4'd4, 10'd1, small_weight());
		push_access(bpsp_pkg::CMD_READ, 4'd4, 10'd1, 24'($urandom));
		push_pixel(bpsp_pkg::CMD_TRAIN, 0, 4'd0, 0);
		push_pixel(bpsp_pkg::CMD_TRAIN, 1, 4'd7, 0);

		// random mix: short images, weight traffic around them
		for (int k = 0; k < 300; ) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				pick = $urandom_range(1, USED_COLS);
				push_image($urandom_range(0, 1) ? bpsp_pkg::CMD_TRAIN : bpsp_pkg::CMD_CLASSIFY,
					pick, 4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0,
					$urandom_range(0, 9) == 0);
				k += pick;
			end else if (pick < 70) begin
				if ($urandom_range(0, 7) == 0)
					push_outside(bpsp_pkg::CMD_READ);
				else
					push_access(bpsp_pkg::CMD_READ, 4'($urandom_range(0, NCLS - 1)), written_col(),
						24'($urandom));
				k++;
			end else begin
				if ($urandom_range(0, 7) == 0)
					push_outside(bpsp_pkg::CMD_WRITE);
				else
					push_access(bpsp_pkg::CMD_WRITE, 4'($urandom_range(0, NCLS - 1)), written_col(),
						$urandom_range(0, 9) == 0 ? 24'($urandom) : small_weight());
				k++;
			end
		end
	end

	// ---- reset and bus defaults ----
	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		s_tuser = '0;
		m_tready = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// driver: new transaction at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !took)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 0;
			end else if (pending_items.size() > 0
				&& !(pending_items[0].drain && expected_results.size() > 0)) begin
				if (pending_items.size() > 80 && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 13);
					s_tvalid <= 0;
				end else begin
					on_bus = pending_items.pop_front();
					s_tdata <= {5'd0, on_bus.target, on_bus.px, on_bus.wval, on_bus.widx,
						on_bus.cls};
					s_tlast <= on_bus.last;
					s_tuser <= on_bus.cmd;
					s_tvalid <= 1;
				end
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// receiver: random stall bursts, none near the end
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 0;
			end else if (pending_items.size() > 80 && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(0, 13);
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	// monitor: predict on input transactions, compare output transactions
	always @(posedge clk) begin
		outcome_t want;
		took = s_tvalid && s_tready;
		if (arst_n && took) predict_item(on_bus);
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_results.pop_front();
				if (m_tuser !== want.kind) note_mismatch("result_kind", m_tuser, want.kind);
				if (m_tdata[23:0] !== want.wdata)
					note_mismatch("weight_data", $signed(m_tdata[23:0]), $signed(want.wdata));
				if (m_tdata[27:24] !== want.best) note_mismatch("best_class", m_tdata[27:24], want.best);
				if (m_tdata[43:28] !== want.prob) note_mismatch("best_prob", m_tdata[43:28], want.prob);
				if (m_tdata[44] !== want.err) note_mismatch("image_error", m_tdata[44], want.err);
			end
		end
	end

	// end of run: all sent, all back, then room for a training sweep
	initial begin
		@(posedge arst_n);
		while (pending_items.size() > 0 || s_tvalid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (30000) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("[binary_pixel_softmax_perceptron] OK");
		end else begin
			$display("[binary_pixel_softmax_perceptron] ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[binary_pixel_softmax_perceptron] ERROR");
		$finish;
	end
endmodule
